@@ design/fdc_pkg.sv @@
package fdc_pkg;

  localparam int unsigned COORD_BITS_DEF = 11;

  localparam int unsigned SPEED_W = 11;
  localparam int unsigned TURN_W  = 8;
  localparam int unsigned DRIVE_W = 11;

  localparam int unsigned STOP_GAP_W = 10;
  localparam int unsigned DEADZONE_W = 9;
  localparam int unsigned STEP_W     = 4;
  localparam int unsigned SEARCH_W   = 9;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_STOP_GAP     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_STEP    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_DRIVE = 8'd3;

  localparam logic [STOP_GAP_W-1:0] STOP_GAP_RST     = 10'd70;
  localparam logic [DEADZONE_W-1:0] DEADZONE_RST     = 9'd351;
  localparam logic [STEP_W-1:0]     SLEW_STEP_RST    = 4'd4;
  localparam logic [SEARCH_W-1:0]   SEARCH_DRIVE_RST = 9'd300;

  localparam int unsigned GAP_CAP  = 508;
  localparam int unsigned TURN_CAP = 508;

  typedef struct packed {
    logic [STOP_GAP_W-1:0] stop_gap;
    logic [DEADZONE_W-1:0] deadzone;
    logic [STEP_W-1:0]     slew_step;
    logic [SEARCH_W-1:0]   search_drive;
  } cfg_t;

  typedef struct packed {
    logic                      searching;
    logic                      target_near;
    logic signed [DRIVE_W-1:0] right_drive;
    logic signed [DRIVE_W-1:0] left_drive;
  } res_t;

endpackage

@@ design/fdc_gap_lane.sv @@
module fdc_gap_lane import fdc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned ROOT_W = COORD_BITS + 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  output logic                         done_o,
  output logic [ROOT_W-1:0]            gap_o
);

  localparam int unsigned DIFF_W = COORD_BITS + 1;
  localparam int unsigned SQ_W   = 2 * COORD_BITS;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned CNT_W  = $clog2(ROOT_W);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_SQR  = 2'd1;
  localparam logic [1:0] L_SUM  = 2'd2;
  localparam logic [1:0] L_ROOT = 2'd3;

  logic [1:0]               state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     done_q, done_d;
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  logic [SQ_W-1:0]          sqx_q, sqy_q;
  logic [RAD_W-1:0]         rad_q;
  logic [REM_W-1:0]         rem_q;
  logic [ROOT_W-1:0]        root_q;

  logic signed [2*DIFF_W-1:0] prod_x, prod_y;
  logic [SQ_W:0]              sq_sum;
  logic [REM_W-1:0]           rem_sh, trial;

  assign prod_x = dx_q * dx_q;
  assign prod_y = dy_q * dy_q;
  assign sq_sum = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      L_IDLE: if (start_i) state_d = L_SQR;
      L_SQR:  state_d = L_SUM;
      L_SUM: begin
        state_d = L_ROOT;
        cnt_d   = '0;
      end
      L_ROOT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ROOT_W - 1)) begin
          state_d = L_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == L_IDLE && start_i) begin
      dx_q <= DIFF_W'(a_x_i) - DIFF_W'(b_x_i);
      dy_q <= DIFF_W'(a_y_i) - DIFF_W'(b_y_i);
    end
    if (state_q == L_SQR) begin
      sqx_q <= prod_x[SQ_W-1:0];
      sqy_q <= prod_y[SQ_W-1:0];
    end
    if (state_q == L_SUM) begin
      rad_q  <= RAD_W'({sq_sum, 8'd0});
      rem_q  <= '0;
      root_q <= '0;
    end
    if (state_q == L_ROOT) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign gap_o  = root_q;

endmodule

@@ design/fdc_merge.sv @@
module fdc_merge import fdc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned ROOT_W = COORD_BITS + 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic                         dots_valid_i,
  input  logic signed [COORD_BITS-1:0] dot1_x_i,
  input  logic [ROOT_W-1:0]            gap0_i,
  input  logic [ROOT_W-1:0]            gap1_i,
  input  cfg_t                         cfg_i,
  input  logic                         out_free_i,
  output logic                         res_valid_o,
  output res_t                         res_o
);

  localparam int unsigned MEAN_W = ROOT_W - 4;
  localparam int unsigned CMP_W  = MEAN_W + STOP_GAP_W;
  localparam int unsigned TGT_W  = 10;
  localparam int unsigned PX_W   = (COORD_BITS > 10) ? COORD_BITS + 1 : 11;
  localparam int unsigned SW_W   = SPEED_W + 2;
  localparam int unsigned TW_W   = TURN_W + 2;

  localparam logic M_IDLE = 1'b0;
  localparam logic M_MIX  = 1'b1;

  logic state_q, state_d;
  logic signed [SPEED_W-1:0] speed_q, speed_d;
  logic signed [TURN_W-1:0]  turn_q, turn_d;

  logic                     near_q, dots_q;
  logic [TGT_W-1:0]         tgt_q;
  logic signed [TURN_W-1:0] tturn_q;

  logic [ROOT_W:0]          gap_sum;
  logic [CMP_W-1:0]         mean_ext, cap;
  logic                     near_a;
  logic [5:0]               tgt6;
  logic [TGT_W-1:0]         tgt_a;
  logic signed [PX_W-1:0]   px, pxc, pxd;
  logic signed [TURN_W-1:0] tturn_a;

  assign gap_sum  = {1'b0, gap0_i} + {1'b0, gap1_i};
  assign mean_ext = CMP_W'(gap_sum[ROOT_W:5]);
  assign near_a   = mean_ext < CMP_W'(cfg_i.stop_gap);
  assign cap      = (mean_ext > CMP_W'(GAP_CAP)) ? CMP_W'(GAP_CAP) : mean_ext;
  assign tgt6     = cap[8:3];
  assign tgt_a    = (tgt6 != '0) ? (TGT_W'(tgt6) + TGT_W'(cfg_i.deadzone)) : '0;

  always_comb begin
    px = PX_W'(dot1_x_i);
    if (px < -$signed(PX_W'(TURN_CAP))) begin
      pxc = -$signed(PX_W'(TURN_CAP));
    end else if (px > $signed(PX_W'(TURN_CAP))) begin
      pxc = $signed(PX_W'(TURN_CAP));
    end else begin
      pxc = px;
    end
    if (pxc < 0) begin
      pxd = (pxc + PX_W'(7)) >>> 3;
    end else begin
      pxd = pxc >>> 3;
    end
    tturn_a = pxd[TURN_W-1:0];
  end

  logic signed [SW_W-1:0] s_cur, s_tgt, s_step, s_dz, s1, s2, s3;
  logic signed [TW_W-1:0] t_cur, t_tgt, t_step, t1, t2;
  logic signed [SPEED_W-1:0] speed_new;
  logic signed [TURN_W-1:0]  turn_new;
  res_t res_d;

  always_comb begin
    s_cur  = SW_W'(speed_q);
    s_tgt  = $signed(SW_W'(tgt_q));
    s_step = $signed(SW_W'(cfg_i.slew_step));
    s_dz   = $signed(SW_W'(cfg_i.deadzone));
    s1 = (s_cur < s_tgt) ? s_cur + s_step : s_cur;
    s2 = (s1 > s_tgt) ? s1 - s_step : s1;
    s3 = (s2 > 0 && s2 < s_dz && tgt_q != '0) ? s_dz : s2;
    speed_new = s3[SPEED_W-1:0];

    t_cur  = TW_W'(turn_q);
    t_tgt  = TW_W'(tturn_q);
    t_step = $signed(TW_W'(cfg_i.slew_step));
    t1 = (t_cur < t_tgt) ? t_cur + t_step : t_cur;
    t2 = (t1 > t_tgt) ? t1 - t_step : t1;
    turn_new = t2[TURN_W-1:0];

    speed_d = speed_q;
    turn_d  = turn_q;
    res_d   = '0;
    if (!dots_q) begin
      res_d.searching = 1'b1;
      if (turn_q <= 0) begin
        res_d.left_drive = DRIVE_W'(cfg_i.search_drive);
      end else begin
        res_d.right_drive = DRIVE_W'(cfg_i.search_drive);
      end
    end else if (near_q) begin
      speed_d           = '0;
      turn_d            = '0;
      res_d.target_near = 1'b1;
    end else begin
      speed_d           = speed_new;
      turn_d            = turn_new;
      res_d.left_drive  = speed_new + DRIVE_W'(turn_new);
      res_d.right_drive = speed_new - DRIVE_W'(turn_new);
    end
  end

  always_comb begin
    state_d     = state_q;
    res_valid_o = 1'b0;
    unique case (state_q)
      M_IDLE: if (go_i) state_d = M_MIX;
      M_MIX: begin
        if (out_free_i) begin
          state_d     = M_IDLE;
          res_valid_o = 1'b1;
        end
      end
      default: state_d = M_IDLE;
    endcase
  end

  assign res_o = res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      speed_q <= '0;
      turn_q  <= '0;
    end else begin
      state_q <= state_d;
      if (res_valid_o) begin
        speed_q <= speed_d;
        turn_q  <= turn_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == M_IDLE && go_i) begin
      near_q  <= near_a;
      dots_q  <= dots_valid_i;
      tgt_q   <= tgt_a;
      tturn_q <= tturn_a;
    end
  end

  a_near_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.target_near |-> res_o.left_drive == '0 && res_o.right_drive == '0)
    else $error("near result with non-zero drive");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_o.target_near && res_o.searching))
    else $error("near and searching both set");

  a_search_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.searching |=> $stable(speed_q) && $stable(turn_q))
    else $error("state changed while searching");

endmodule

@@ design/follower_drive_controller.sv @@
// Drive controller for a vision follower. Each input transfer carries one frame's
// result: dots_valid in tuser and three signed dot coordinates in tdata. Two lanes
// each measure one neighbouring-dot distance with a bit-serial square root; a merge
// stage averages them, stops the robot when the target is near, otherwise slews speed
// and turn and mixes them into left and right drives, and spins on one side while the
// target is lost. One item is in flight at a time: its coordinate differences are
// registered, squared and summed, then each lane runs COORD_BITS + 5 iterations of
// the square root, and the merge stage loads the result into the output register.
// A new item is taken once the previous result sits in the output register; a
// stalled output holds the merge stage and the input.
// Configuration writes are always ready.
module follower_drive_controller import fdc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned IN_TDATA_W = ((6 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_TDATA_W = ((2 * DRIVE_W + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // dot0_x, dot0_y, dot1_x, dot1_y, dot2_x, dot2_y
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // dots_valid
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // left_drive, right_drive
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // target_near, searching
  output logic [1:0]             m_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned ROOT_W = COORD_BITS + 5;
  localparam int unsigned CB = COORD_BITS;

  cfg_t cfg_q;
  logic busy_q;
  logic dots_valid_q;
  logic signed [CB-1:0] dot1_x_q;
  logic m_valid_q;
  res_t m_res_q;

  logic s_accept;
  logic out_free;
  logic res_valid;
  res_t res;
  logic [1:0] lane_done;
  logic [ROOT_W-1:0] gap0, gap1;

  logic signed [CB-1:0] d0x, d0y, d1x, d1y, d2x, d2y;

  assign d0x = s_axis_tdata[0*CB +: CB];
  assign d0y = s_axis_tdata[1*CB +: CB];
  assign d1x = s_axis_tdata[2*CB +: CB];
  assign d1y = s_axis_tdata[3*CB +: CB];
  assign d2x = s_axis_tdata[4*CB +: CB];
  assign d2y = s_axis_tdata[5*CB +: CB];

  assign s_axis_tready = !busy_q;
  assign s_accept      = s_axis_tvalid && !busy_q;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_gap     <= STOP_GAP_RST;
      cfg_q.deadzone     <= DEADZONE_RST;
      cfg_q.slew_step    <= SLEW_STEP_RST;
      cfg_q.search_drive <= SEARCH_DRIVE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_STOP_GAP:     cfg_q.stop_gap     <= cfg_data_i;
        REG_DEADZONE:     cfg_q.deadzone     <= cfg_data_i[DEADZONE_W-1:0];
        REG_SLEW_STEP:    cfg_q.slew_step    <= cfg_data_i[STEP_W-1:0];
        REG_SEARCH_DRIVE: cfg_q.search_drive <= cfg_data_i[SEARCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        busy_q <= 1'b1;
      end else if (res_valid) begin
        busy_q <= 1'b0;
      end
      if (res_valid) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      dots_valid_q <= s_axis_tuser;
      dot1_x_q     <= d1x;
    end
    if (res_valid) begin
      m_res_q <= res;
    end
  end

  fdc_gap_lane #(.COORD_BITS(COORD_BITS)) u_lane0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s_accept),
    .a_x_i   (d0x),
    .a_y_i   (d0y),
    .b_x_i   (d1x),
    .b_y_i   (d1y),
    .done_o  (lane_done[0]),
    .gap_o   (gap0)
  );

  fdc_gap_lane #(.COORD_BITS(COORD_BITS)) u_lane1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s_accept),
    .a_x_i   (d1x),
    .a_y_i   (d1y),
    .b_x_i   (d2x),
    .b_y_i   (d2y),
    .done_o  (lane_done[1]),
    .gap_o   (gap1)
  );

  fdc_merge #(.COORD_BITS(COORD_BITS)) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .go_i         (lane_done[0]),
    .dots_valid_i (dots_valid_q),
    .dot1_x_i     (dot1_x_q),
    .gap0_i       (gap0),
    .gap1_i       (gap1),
    .cfg_i        (cfg_q),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({m_res_q.right_drive, m_res_q.left_drive});
  assign m_axis_tuser  = {m_res_q.searching, m_res_q.target_near};

  a_lanes_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_done[0] == lane_done[1])
    else $error("lanes finished out of step");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> busy_q && out_free)
    else $error("result without an item in flight or with output full");

endmodule
